/* hw/rtl/sitda_pkg.sv */
package sitda_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int DIGIT_DEPTH = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int DIGIT_IDX_W = $clog2(DIGIT_DEPTH);
   localparam int TEXT_W      = $clog2(DIGIT_DEPTH + 2);
   localparam int STEP_W      = $clog2(VALUE_BITS);
   localparam int LEN_W       = 4;
   localparam int LIMIT_W     = 8;
   localparam int CHAR_W      = 8;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VALUE_BITS - 1);

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

   localparam logic [3:0] DABBLE_LIMIT = 4'd5;
   localparam logic [3:0] DABBLE_ADJ   = 4'd3;

   typedef logic [3:0] digit_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_COUNT,
      ST_EMIT
   } state_type;

endpackage

/* hw/rtl/sitda_if.sv */
interface sitda_req_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [sitda_pkg::VALUE_BITS-1:0]     value;
   logic        [sitda_pkg::LIMIT_W-1:0]        max_len;

   modport source (output valid, value, max_len, input ready);
   modport sink   (input valid, value, max_len, output ready);
endinterface

interface sitda_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic [sitda_pkg::CHAR_W-1:0]                char_code;
   logic                                        last;
   logic [sitda_pkg::LEN_W-1:0]                 length;

   modport source (output valid, char_code, last, length, input ready);
   modport sink   (input valid, char_code, last, length, output ready);
endinterface

/* hw/rtl/sitda_cell.sv */
module sitda_cell (
   input  logic                     clock,
   input  sitda_pkg::cell_ctrl_type ctrl,
   input  logic                     bit_in,
   output logic                     bit_out,
   output sitda_pkg::digit_type     digit
);

   sitda_pkg::digit_type digit_ff;
   sitda_pkg::digit_type digit_in;
   sitda_pkg::digit_type adj;

   // add-3 correction before the shift
   always_comb begin
      adj = (digit_ff >= sitda_pkg::DABBLE_LIMIT) ? digit_ff + sitda_pkg::DABBLE_ADJ
                                                   : digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.shift) begin
         digit_in = {adj[2:0], bit_in};
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign bit_out = adj[3];
   assign digit   = digit_ff;

endmodule

/* hw/rtl/signed_int_to_decimal_ascii_unit.sv */
// Signed integer to decimal ASCII text.
// req_if carries one transaction per conversion: value (signed) and max_len.
// rsp_if returns one transaction per character, most significant first:
// char_code ('-' or '0'..'9'), last on the final character and length, the
// character count after truncation to max_len. max_len of 0 gives nothing.
// A new request is taken only while the unit is idle. Each conversion runs
// shift-and-add-3 through a row of BCD digit cells (one bit per cycle),
// then locates the leading digit and fixes the truncated length, then
// sends one character per cycle into the output register while the
// receiver keeps up. The next request can be accepted once the unit is
// back in idle, while the last character may still sit in the output
// register. When the receiver stalls, the output register holds its
// character and the emitter waits; nothing is dropped.
// Synchronous reset returns the unit to idle with no output pending; the
// digit cells are cleared at the start of every conversion, not by reset.
module signed_int_to_decimal_ascii_unit (
   input  logic        clock,
   input  logic        reset,
   sitda_req_if.sink   req_if,
   sitda_rsp_if.source rsp_if
);

   localparam int VB = sitda_pkg::VALUE_BITS;
   localparam int DD = sitda_pkg::DIGIT_DEPTH;
   localparam int TW = sitda_pkg::TEXT_W;

   sitda_pkg::state_type state_ff, state_in;
   logic [sitda_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [VB-1:0]                 mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic [sitda_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [TW-1:0]                 ndig_ff, ndig_in;
   logic [TW-1:0]                 total_ff, total_in;
   logic [TW-1:0]                 pos_ff, pos_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sitda_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic [sitda_pkg::LEN_W-1:0]   rsp_length_ff, rsp_length_in;

   sitda_pkg::cell_ctrl_type      cell_ctrl;
   sitda_pkg::digit_type          digits [DD];
   logic [DD:0]                   carry;

   logic                          accept;
   logic                          out_free;
   logic [VB-1:0]                 raw;
   logic [TW-1:0]                 ndig_scan;
   logic [TW-1:0]                 text_len;
   logic [TW-1:0]                 k;
   logic [TW-1:0]                 idx;
   logic                          is_last;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign raw      = $unsigned(req_if.value);

   assign cell_ctrl.clear = accept;
   assign cell_ctrl.shift = (state_ff == sitda_pkg::ST_CONVERT);
   assign carry[0]        = mag_ff[VB-1];

   for (genvar i = 0; i < DD; i++) begin : g_cell
      sitda_cell u_cell (
         .clock   (clock),
         .ctrl    (cell_ctrl),
         .bit_in  (carry[i]),
         .bit_out (carry[i+1]),
         .digit   (digits[i])
      );
   end

   // highest non-zero digit; zero still gives one digit
   always_comb begin
      ndig_scan = TW'(1);
      for (int i = 0; i < DD; i++) begin
         if (digits[i] != '0) begin
            ndig_scan = TW'(i + 1);
         end
      end
   end

   assign text_len = ndig_scan + TW'(neg_ff);
   assign k        = pos_ff - TW'(neg_ff);
   assign idx      = ndig_ff - TW'(1) - k;
   assign is_last  = (pos_ff + TW'(1)) == total_ff;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      limit_in      = limit_ff;
      ndig_in       = ndig_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_length_in = rsp_length_ff;

      unique case (state_ff)
         sitda_pkg::ST_IDLE: begin
            if (accept) begin
               neg_in   = raw[VB-1];
               mag_in   = raw[VB-1] ? (~raw + VB'(1)) : raw;
               limit_in = req_if.max_len;
               step_in  = '0;
               state_in = sitda_pkg::ST_CONVERT;
            end
         end
         sitda_pkg::ST_CONVERT: begin
            mag_in  = mag_ff << 1;
            step_in = step_ff + 1'b1;
            if (step_ff == sitda_pkg::STEP_LAST) begin
               state_in = sitda_pkg::ST_COUNT;
            end
         end
         sitda_pkg::ST_COUNT: begin
            ndig_in  = ndig_scan;
            state_in = sitda_pkg::ST_EMIT;
         end
         sitda_pkg::ST_EMIT: begin
            // total and ndig both registered in the count phase
            if (total_ff == '0) begin
               state_in = sitda_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = is_last;
               rsp_length_in = sitda_pkg::LEN_W'(total_ff);
               if (neg_ff && (pos_ff == '0)) begin
                  rsp_char_in = sitda_pkg::CH_MINUS;
               end else begin
                  rsp_char_in = sitda_pkg::CH_ZERO
                              + sitda_pkg::CHAR_W'(digits[idx[sitda_pkg::DIGIT_IDX_W-1:0]]);
               end
               pos_in = pos_ff + TW'(1);
               if (is_last) begin
                  state_in = sitda_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sitda_pkg::ST_IDLE;
         end
      endcase

      // character index restarts before EMIT
      if (state_ff == sitda_pkg::ST_COUNT) begin
         pos_in = '0;
      end
   end

   // truncated length from the digit scan, captured in the count phase
   always_comb begin
      if (limit_ff < sitda_pkg::LIMIT_W'(text_len)) begin
         total_in = TW'(limit_ff);
      end else begin
         total_in = text_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sitda_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      limit_ff      <= limit_in;
      ndig_ff       <= ndig_in;
      pos_ff        <= pos_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_length_ff <= rsp_length_in;
      if (state_ff != sitda_pkg::ST_EMIT) begin
         total_ff <= total_in;
      end
   end

   assign req_if.ready     = (state_ff == sitda_pkg::ST_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.char_code = rsp_char_ff;
   assign rsp_if.last      = rsp_last_ff;
   assign rsp_if.length    = rsp_length_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == sitda_pkg::ST_CONVERT) && (step_ff == '0))
      else $error("conversion did not start after request");

   a_count_after_convert: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sitda_pkg::ST_COUNT) |-> ($past(state_ff) == sitda_pkg::ST_CONVERT))
      else $error("count phase entered out of order");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sitda_pkg::ST_EMIT) && (total_ff != '0) |-> (pos_ff < total_ff))
      else $error("character index beyond truncated length");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_length_ff != '0) &&
         ((rsp_char_ff == sitda_pkg::CH_MINUS) ||
          ((rsp_char_ff >= sitda_pkg::CH_ZERO) && (rsp_char_ff <= sitda_pkg::CH_NINE))))
      else $error("illegal character or zero length on output");

endmodule
